FILE: rtl/core/bil_pkg.sv
// ----------------------------------------------------------------------------
// bil_pkg
// Shared types and codes for the bounded indexed list
// ----------------------------------------------------------------------------
package bil_pkg;

   localparam int FIELD_W = 32;
   localparam int POS_W   = 7;
   localparam int CMD_W   = 3;
   localparam int STAT_W  = 2;
   localparam int LEN_W   = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_FRONT    = 3'd0,
      CMD_ADD_BACK     = 3'd1,
      CMD_INSERT_AT    = 3'd2,
      CMD_REMOVE_FRONT = 3'd3,
      CMD_REMOVE_BACK  = 3'd4,
      CMD_REMOVE_AT    = 3'd5,
      CMD_READ_AT      = 3'd6,
      CMD_NOP          = 3'd7
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PUT,
      ST_READ_RD,
      ST_FRONT_RD,
      ST_BACK_RD,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/core/bounded_indexed_list.sv
// ----------------------------------------------------------------------------
// bounded_indexed_list
// Ordered list with front/back/indexed insert, remove and read
// steps: a read/write pair per entry that moves, then the write of an insertion
// or the read of a read, then the front read, back read and the response beat
// throughput: one command at a time; the next is taken the cycle after the
// response register loads, and a held response beat stalls only the last step
// reset clears the item count and the control state; the store is not cleared
// ----------------------------------------------------------------------------
module bounded_indexed_list #(
   parameter int CAPACITY   = 64,
   parameter int ITEM_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[2:0], position[9:3], item_value[41:10], zero pad
   input  logic [47:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], read_value[33:2], front_value[65:34], back_value[97:66],
   // length[104:98], is_empty[105], zero pad
   output logic [111:0] rsp_tdata
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > bil_pkg::POS_W) ? CW : bil_pkg::POS_W;

   bil_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       at_ff, at_in;
   logic                up_ff, up_in;
   logic                reading_ff, reading_in;
   logic [ITEM_WIDTH-1:0] val_ff, val_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [111:0]        rsp_data_ff, rsp_data_in;
   bil_pkg::status_type status_ff, status_in;
   logic [bil_pkg::FIELD_W-1:0] rd_ff, rd_in;
   logic [bil_pkg::FIELD_W-1:0] front_ff, front_in;
   logic [bil_pkg::FIELD_W-1:0] back_now;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ITEM_WIDTH-1:0] wr_data;
   logic [AW-1:0]         rd_addr;
   logic [ITEM_WIDTH-1:0] rd_data;

   bil_pkg::cmd_type          cmd;
   logic [bil_pkg::POS_W-1:0] pos;
   logic                      full, empty, pos_ok, accept, rsp_free;
   logic [CW-1:0]             at_pos, at_sel, idx_step;

   assign cmd      = bil_pkg::cmd_type'(req_tdata[2:0]);
   assign pos      = req_tdata[9:3];
   assign full     = (count_ff == CW'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign pos_ok   = (pos != '0) && (CMPW'(pos) <= CMPW'(count_ff));
   assign at_pos   = CW'(pos - 7'd1);
   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign back_now = empty ? '0 : bil_pkg::FIELD_W'(rd_data);

   assign req_tready = (state_ff == bil_pkg::ST_IDLE);

   bil_store #(
      .DEPTH (CAPACITY),
      .WIDTH (ITEM_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bil_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      at_ff       <= at_in;
      up_ff       <= up_in;
      reading_ff  <= reading_in;
      val_ff      <= val_in;
      status_ff   <= status_in;
      rd_ff       <= rd_in;
      front_ff    <= front_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      at_in        = at_ff;
      up_in        = up_ff;
      reading_in   = reading_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      status_in    = status_ff;
      rd_in        = rd_ff;
      front_in     = front_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = rd_data;
      rd_addr      = '0;
      at_sel       = at_pos;
      idx_step     = up_ff ? (idx_ff - 1'b1) : (idx_ff + 1'b1);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         bil_pkg::ST_IDLE: begin
            if (accept) begin
               status_in  = bil_pkg::STAT_OK;
               rd_in      = '0;
               reading_in = 1'b0;
               val_in     = ITEM_WIDTH'(req_tdata[41:10]);
               state_in   = bil_pkg::ST_FRONT_RD;
               case (cmd)
                  bil_pkg::CMD_ADD_FRONT, bil_pkg::CMD_ADD_BACK,
                  bil_pkg::CMD_INSERT_AT: begin
                     if (cmd == bil_pkg::CMD_ADD_FRONT) begin
                        at_sel = '0;
                     end else if (cmd == bil_pkg::CMD_ADD_BACK) begin
                        at_sel = count_ff;
                     end
                     if (full) begin
                        status_in = bil_pkg::STAT_FULL;
                     end else if (cmd == bil_pkg::CMD_INSERT_AT && !pos_ok) begin
                        status_in = bil_pkg::STAT_RANGE;
                     end else begin
                        at_in    = at_sel;
                        idx_in   = count_ff;
                        up_in    = 1'b1;
                        count_in = count_ff + 1'b1;
                        state_in = (count_ff > at_sel) ? bil_pkg::ST_SHIFT_RD
                                                       : bil_pkg::ST_PUT;
                     end
                  end
                  bil_pkg::CMD_REMOVE_FRONT, bil_pkg::CMD_REMOVE_BACK,
                  bil_pkg::CMD_REMOVE_AT: begin
                     if (cmd == bil_pkg::CMD_REMOVE_FRONT) begin
                        at_sel = '0;
                     end else if (cmd == bil_pkg::CMD_REMOVE_BACK) begin
                        at_sel = count_ff - 1'b1;
                     end
                     if (empty) begin
                        status_in = bil_pkg::STAT_EMPTY;
                     end else if (cmd == bil_pkg::CMD_REMOVE_AT && !pos_ok) begin
                        status_in = bil_pkg::STAT_RANGE;
                     end else begin
                        at_in    = at_sel;
                        idx_in   = at_sel;
                        up_in    = 1'b0;
                        count_in = count_ff - 1'b1;
                        state_in = (at_sel < (count_ff - 1'b1)) ? bil_pkg::ST_SHIFT_RD
                                                                : bil_pkg::ST_FRONT_RD;
                     end
                  end
                  bil_pkg::CMD_READ_AT: begin
                     if (empty) begin
                        status_in = bil_pkg::STAT_EMPTY;
                     end else if (!pos_ok) begin
                        status_in = bil_pkg::STAT_RANGE;
                     end else begin
                        at_in      = at_pos;
                        reading_in = 1'b1;
                        state_in   = bil_pkg::ST_READ_RD;
                     end
                  end
                  default: begin
                     state_in = bil_pkg::ST_FRONT_RD;
                  end
               endcase
            end
         end
         bil_pkg::ST_SHIFT_RD: begin
            rd_addr  = up_ff ? AW'(idx_ff - 1'b1) : AW'(idx_ff + 1'b1);
            state_in = bil_pkg::ST_SHIFT_WR;
         end
         bil_pkg::ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_ff);
            wr_data = rd_data;
            idx_in  = idx_step;
            if (up_ff) begin
               state_in = (idx_step > at_ff) ? bil_pkg::ST_SHIFT_RD : bil_pkg::ST_PUT;
            end else begin
               state_in = (idx_step < count_ff) ? bil_pkg::ST_SHIFT_RD
                                                : bil_pkg::ST_FRONT_RD;
            end
         end
         bil_pkg::ST_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(at_ff);
            wr_data  = val_ff;
            state_in = bil_pkg::ST_FRONT_RD;
         end
         bil_pkg::ST_READ_RD: begin
            rd_addr  = AW'(at_ff);
            state_in = bil_pkg::ST_FRONT_RD;
         end
         bil_pkg::ST_FRONT_RD: begin
            rd_addr = '0;
            if (reading_ff) begin
               rd_in = bil_pkg::FIELD_W'(rd_data);
            end
            state_in = bil_pkg::ST_BACK_RD;
         end
         bil_pkg::ST_BACK_RD: begin
            rd_addr  = AW'(count_ff - 1'b1);
            front_in = empty ? '0 : bil_pkg::FIELD_W'(rd_data);
            state_in = bil_pkg::ST_DONE;
         end
         bil_pkg::ST_DONE: begin
            // keep the back entry on the read port while the output is held
            rd_addr = AW'(count_ff - 1'b1);
            if (rsp_free) begin
               rsp_data_in  = {6'b0,
                               empty,
                               bil_pkg::LEN_W'(count_ff),
                               back_now,
                               front_ff,
                               rd_ff,
                               status_ff};
               rsp_valid_in = 1'b1;
               state_in     = bil_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bil_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // count stays within the capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("item count beyond capacity");

   // an accepted command always leaves idle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != bil_pkg::ST_IDLE)
      else $error("command accepted but sequencer stayed idle");

   // a full status is only reported with a full list
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[1:0] == bil_pkg::STAT_FULL)
         |-> rsp_data_ff[104:98] == bil_pkg::LEN_W'(CAPACITY))
      else $error("full status with room left");

   // an empty status is only reported with an empty list
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[1:0] == bil_pkg::STAT_EMPTY) |-> rsp_data_ff[105])
      else $error("empty status with items held");

   // a held response beat does not change
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("response beat changed while held");

endmodule

FILE: rtl/core/bil_store.sv
// ----------------------------------------------------------------------------
// bil_store
// Item store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bil_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
